/* rtl/superpixel_weighted_distance_core_macros.svh */
// Assertion macros for the superpixel weighted distance core.
// Included by the checker module; depends on nothing else.
`ifndef SUPERPIXEL_WEIGHTED_DISTANCE_CORE_MACROS_SVH
`define SUPERPIXEL_WEIGHTED_DISTANCE_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SWD_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("swd check failed: condition");

// An implication checked outside reset.
`define SWD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swd check failed: implication");

// An implication that is also checked while reset is high.
`define SWD_ASSERT_RESET(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("swd check failed: reset behaviour");

`endif

/* rtl/swd_pkg.sv */
// Shared types, constants and width helpers for the weighted distance core.
// Depends on nothing; imported by every module of the block.
package swd_pkg;

   localparam int COLOUR_W   = 8;
   localparam int MEAN_W     = 12;
   localparam int PIX_POS_W  = 12;
   localparam int CEN_POS_W  = 16;
   localparam int HGT_W      = 24;
   localparam int HDIFF_W    = 25;
   localparam int STEP_W     = 12;
   localparam int OUT_W      = 25;
   localparam int COL_RAD_W  = 38;
   localparam int COL_ROOT_W = COL_RAD_W / 2;
   localparam int COLOUR_DIVISOR = 255;
   localparam logic [STEP_W-1:0] GRID_STEP_RESET = 12'd16;
   localparam logic [OUT_W-1:0]  OUT_MAX = {OUT_W{1'b1}};

   // Reciprocal of the colour divisor, rounded up; exact for every colour root
   // below 2^19 because the rounding error times the largest root stays under 2^27.
   localparam int COL_RECIP_SHIFT = 27;
   localparam int COL_RECIP_W     = 20;
   localparam logic [COL_RECIP_W-1:0] COL_RECIP =
      COL_RECIP_W'(((64'd1 << COL_RECIP_SHIFT) + COLOUR_DIVISOR - 1) / COLOUR_DIVISOR);

   // Radicand width shared by both square-root lanes (even, so whole digit pairs).
   function automatic int swd_rad_width(input int coord_bits);
      int pos_w;
      pos_w = 2 * (coord_bits + 4) + 1 + 8;
      pos_w = pos_w + (pos_w % 2);
      return (pos_w > COL_RAD_W) ? pos_w : COL_RAD_W;
   endfunction

   // Control that travels alongside the arithmetic through every stage.
   typedef struct packed {
      logic                valid;
      logic [STEP_W-1:0]   step;
      logic [HDIFF_W-1:0]  height_diff;
   } swd_ctrl_type;

endpackage

/* rtl/superpixel_weighted_distance_core.sv */
// Top level of the superpixel weighted distance core; depends on swd_pkg, swd_front,
// swd_sqrt and swd_div.
//
// One pixel/center item is taken on every clock in which start is high; busy is
// never raised, so items may follow one another in consecutive cycles. Each item
// yields exactly one rsp_valid strobe once it has passed the front end, the
// square-root pipelines, the grid step divider and the output register. The
// square-root pipelines and the grid step divider each produce one result bit per
// stage; the colour term is divided by 255 with a reciprocal multiply that travels
// alongside. The receiver cannot hold results back and none is buffered: a result
// is present for its single strobe cycle only. grid_step should be written only
// while no item is in flight.
module superpixel_weighted_distance_core
   import swd_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [COLOUR_W-1:0]      req_pixel_blue,
   input  logic [COLOUR_W-1:0]      req_pixel_green,
   input  logic [COLOUR_W-1:0]      req_pixel_red,
   input  logic [PIX_POS_W-1:0]     req_pixel_col,
   input  logic [PIX_POS_W-1:0]     req_pixel_row,
   input  logic signed [HGT_W-1:0]  req_pixel_height,
   input  logic [MEAN_W-1:0]        req_center_blue,
   input  logic [MEAN_W-1:0]        req_center_green,
   input  logic [MEAN_W-1:0]        req_center_red,
   input  logic [CEN_POS_W-1:0]     req_center_col,
   input  logic [CEN_POS_W-1:0]     req_center_row,
   input  logic signed [HGT_W-1:0]  req_center_height,
   input  logic                     csr_write_enable,
   input  logic [STEP_W-1:0]        csr_write_data,
   output logic                     rsp_valid,
   output logic [OUT_W-1:0]         rsp_weighted_distance
);

   localparam int RAD_W = swd_rad_width(COORD_BITS);
   localparam int R     = RAD_W / 2;
   localparam int SUM_W = HDIFF_W + 1;

   logic [STEP_W-1:0]  csr_grid_step_ff;
   logic               accept;
   logic [RAD_W-1:0]   col_rad;
   logic [RAD_W-1:0]   pos_rad;
   swd_ctrl_type       front_ctrl;
   logic [R-1:0]       col_root;
   logic [R-1:0]       pos_root;
   swd_ctrl_type       sqrt_ctrl;
   logic [R-1:0]       col_quot;
   logic [R-1:0]       pos_quot;
   swd_ctrl_type       div_ctrl;
   logic [SUM_W-1:0]   sum;
   logic [OUT_W-1:0]   rsp_dist_in;
   logic [OUT_W-1:0]   rsp_dist_ff;
   logic               rsp_valid_ff;

   // The pipeline never stalls, so the core is always ready.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Grid step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_grid_step_ff <= GRID_STEP_RESET;
      end else if (csr_write_enable) begin
         csr_grid_step_ff <= csr_write_data;
      end
   end

   swd_front #(
      .COORD_BITS (COORD_BITS),
      .RAD_W      (RAD_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pixel_blue    (req_pixel_blue),
      .pixel_green   (req_pixel_green),
      .pixel_red     (req_pixel_red),
      .pixel_col     (req_pixel_col),
      .pixel_row     (req_pixel_row),
      .pixel_height  (req_pixel_height),
      .center_blue   (req_center_blue),
      .center_green  (req_center_green),
      .center_red    (req_center_red),
      .center_col    (req_center_col),
      .center_row    (req_center_row),
      .center_height (req_center_height),
      .grid_step     (csr_grid_step_ff),
      .col_rad       (col_rad),
      .pos_rad       (pos_rad),
      .ctrl          (front_ctrl)
   );

   swd_sqrt #(
      .RAD_W (RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .col_rad  (col_rad),
      .pos_rad  (pos_rad),
      .ctrl_i   (front_ctrl),
      .col_root (col_root),
      .pos_root (pos_root),
      .ctrl_o   (sqrt_ctrl)
   );

   swd_div #(
      .N (R)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .col_num  (col_root),
      .pos_num  (pos_root),
      .ctrl_i   (sqrt_ctrl),
      .col_quot (col_quot),
      .pos_quot (pos_quot),
      .ctrl_o   (div_ctrl)
   );

   // Final stage: add the two truncated quotients and the height term, and saturate.
   always_comb begin
      sum = SUM_W'(col_quot) + SUM_W'(pos_quot) + SUM_W'(div_ctrl.height_diff);
      rsp_dist_in = (sum > SUM_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(sum);
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ctrl.valid;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_weighted_distance = rsp_dist_ff;

endmodule

/* rtl/swd_front.sv */
// Front end: differences, squares and scaled sums of squares, three stages.
// Depends on swd_pkg.
module swd_front
   import swd_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int RAD_W      = 42
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [COLOUR_W-1:0]         pixel_blue,
   input  logic [COLOUR_W-1:0]         pixel_green,
   input  logic [COLOUR_W-1:0]         pixel_red,
   input  logic [PIX_POS_W-1:0]        pixel_col,
   input  logic [PIX_POS_W-1:0]        pixel_row,
   input  logic signed [HGT_W-1:0]     pixel_height,
   input  logic [MEAN_W-1:0]           center_blue,
   input  logic [MEAN_W-1:0]           center_green,
   input  logic [MEAN_W-1:0]           center_red,
   input  logic [CEN_POS_W-1:0]        center_col,
   input  logic [CEN_POS_W-1:0]        center_row,
   input  logic signed [HGT_W-1:0]     center_height,
   input  logic [STEP_W-1:0]           grid_step,
   output logic [RAD_W-1:0]            col_rad,
   output logic [RAD_W-1:0]            pos_rad,
   output swd_ctrl_type                ctrl
);

   localparam int PW    = COORD_BITS + 4;
   localparam int CSQ_W = 2 * MEAN_W;
   localparam int S_W   = CSQ_W + 2;
   localparam int PSQ_W = 2 * PW;
   localparam int P_W   = PSQ_W + 1;

   function automatic logic [MEAN_W-1:0] col_absdiff(input logic [MEAN_W-1:0] a,
                                                      input logic [MEAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [PW-1:0] pos_absdiff(input logic [PW-1:0] a,
                                                  input logic [PW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [MEAN_W-1:0]        cdiff_in [0:2];
   logic [MEAN_W-1:0]        cdiff_ff [0:2];
   logic [PW-1:0]            pdiff_in [0:1];
   logic [PW-1:0]            pdiff_ff [0:1];
   logic signed [HDIFF_W-1:0] hdiff;
   swd_ctrl_type             ctrl1_in;
   swd_ctrl_type             ctrl1_ff;
   logic [CSQ_W-1:0]         csq_ff [0:2];
   logic [PSQ_W-1:0]         psq_ff [0:1];
   swd_ctrl_type             ctrl2_ff;
   logic [S_W-1:0]           ssum;
   logic [P_W-1:0]           psum;
   logic [RAD_W-1:0]         col_rad_in;
   logic [RAD_W-1:0]         pos_rad_in;
   logic [RAD_W-1:0]         col_rad_ff;
   logic [RAD_W-1:0]         pos_rad_ff;
   swd_ctrl_type             ctrl3_ff;

   // Stage one: absolute differences in sixteenths, height magnitude, step.
   always_comb begin
      cdiff_in[0] = col_absdiff({pixel_blue, 4'b0000}, center_blue);
      cdiff_in[1] = col_absdiff({pixel_green, 4'b0000}, center_green);
      cdiff_in[2] = col_absdiff({pixel_red, 4'b0000}, center_red);
      pdiff_in[0] = pos_absdiff(PW'({pixel_col, 4'b0000}), PW'(center_col));
      pdiff_in[1] = pos_absdiff(PW'({pixel_row, 4'b0000}), PW'(center_row));
      hdiff = {pixel_height[HGT_W-1], pixel_height} - {center_height[HGT_W-1], center_height};
      ctrl1_in.valid = accept;
      ctrl1_in.step = (grid_step == '0) ? STEP_W'(1) : grid_step;
      ctrl1_in.height_diff = hdiff[HDIFF_W-1] ? HDIFF_W'(-hdiff) : HDIFF_W'(hdiff);
   end

   always_ff @(posedge clock) begin
      cdiff_ff <= cdiff_in;
      pdiff_ff <= pdiff_in;
      if (reset) begin
         ctrl1_ff.valid <= 1'b0;
      end else begin
         ctrl1_ff <= ctrl1_in;
      end
   end

   // Stage two: one square per difference.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         csq_ff[i] <= cdiff_ff[i] * cdiff_ff[i];
      end
      for (int i = 0; i < 2; i++) begin
         psq_ff[i] <= pdiff_ff[i] * pdiff_ff[i];
      end
      if (reset) begin
         ctrl2_ff.valid <= 1'b0;
      end else begin
         ctrl2_ff <= ctrl1_ff;
      end
   end

   // Stage three: sums of squares, colour scaled by 2304 and position by 256.
   always_comb begin
      ssum = S_W'(csq_ff[0]) + S_W'(csq_ff[1]) + S_W'(csq_ff[2]);
      psum = P_W'(psq_ff[0]) + P_W'(psq_ff[1]);
      col_rad_in = RAD_W'({ssum, 11'b0}) + RAD_W'({ssum, 8'b0});
      pos_rad_in = RAD_W'({psum, 8'b0});
   end

   always_ff @(posedge clock) begin
      col_rad_ff <= col_rad_in;
      pos_rad_ff <= pos_rad_in;
      if (reset) begin
         ctrl3_ff.valid <= 1'b0;
      end else begin
         ctrl3_ff <= ctrl2_ff;
      end
   end

   assign col_rad = col_rad_ff;
   assign pos_rad = pos_rad_ff;
   assign ctrl    = ctrl3_ff;

endmodule

/* rtl/swd_sqrt.sv */
// Two-lane pipelined integer square root, one root bit per stage.
// Depends on swd_pkg.
module swd_sqrt
   import swd_pkg::*;
#(
   parameter int RAD_W = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RAD_W-1:0]      col_rad,
   input  logic [RAD_W-1:0]      pos_rad,
   input  swd_ctrl_type          ctrl_i,
   output logic [RAD_W/2-1:0]    col_root,
   output logic [RAD_W/2-1:0]    pos_root,
   output swd_ctrl_type          ctrl_o
);

   localparam int R  = RAD_W / 2;
   localparam int RW = R + 2;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [RW-1:0]    rem;
      logic [R-1:0]     root;
   } sq_lane_type;

   // One restoring step: bring down a digit pair and try the next root bit.
   function automatic sq_lane_type sqrt_step(input sq_lane_type s);
      sq_lane_type  n;
      logic [RW+1:0] cand;
      logic [RW+1:0] trial;
      cand  = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = (RW+2)'({s.root, 2'b01});
      n.rad = s.rad << 2;
      if (cand >= trial) begin
         n.rem  = RW'(cand - trial);
         n.root = {s.root[R-2:0], 1'b1};
      end else begin
         n.rem  = RW'(cand);
         n.root = {s.root[R-2:0], 1'b0};
      end
      return n;
   endfunction

   sq_lane_type  col_ff  [0:R-1];
   sq_lane_type  pos_ff  [0:R-1];
   swd_ctrl_type ctrl_ff [0:R-1];

   for (genvar g = 0; g < R; g++) begin : g_stage
      sq_lane_type  col_src;
      sq_lane_type  pos_src;
      swd_ctrl_type ctrl_src;

      if (g == 0) begin : g_head
         always_comb begin
            col_src.rad  = col_rad;
            col_src.rem  = '0;
            col_src.root = '0;
            pos_src.rad  = pos_rad;
            pos_src.rem  = '0;
            pos_src.root = '0;
            ctrl_src     = ctrl_i;
         end
      end else begin : g_body
         always_comb begin
            col_src  = col_ff[g-1];
            pos_src  = pos_ff[g-1];
            ctrl_src = ctrl_ff[g-1];
         end
      end

      // Stage register for both lanes and the travelling control.
      always_ff @(posedge clock) begin
         col_ff[g] <= sqrt_step(col_src);
         pos_ff[g] <= sqrt_step(pos_src);
         if (reset) begin
            ctrl_ff[g].valid <= 1'b0;
         end else begin
            ctrl_ff[g] <= ctrl_src;
         end
      end
   end

   assign col_root = col_ff[R-1].root;
   assign pos_root = pos_ff[R-1].root;
   assign ctrl_o   = ctrl_ff[R-1];

endmodule

/* rtl/swd_div.sv */
// Two-lane pipelined divider: the position lane divides by the grid step with one
// quotient bit per stage, the colour lane by 255 through a reciprocal multiply; uses swd_pkg.
module swd_div
   import swd_pkg::*;
#(
   parameter int N = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [N-1:0]      col_num,
   input  logic [N-1:0]      pos_num,
   input  swd_ctrl_type      ctrl_i,
   output logic [N-1:0]      col_quot,
   output logic [N-1:0]      pos_quot,
   output swd_ctrl_type      ctrl_o
);

   localparam int CP_W = COL_ROOT_W + COL_RECIP_W;

   typedef struct packed {
      logic [N-1:0]      num;
      logic [STEP_W-1:0] rem;
      logic [N-1:0]      quot;
   } dv_lane_type;

   // Bring down the next numerator bit and subtract the divisor if it fits.
   function automatic dv_lane_type div_step(input dv_lane_type s,
                                            input logic [STEP_W-1:0] den);
      dv_lane_type   n;
      logic [STEP_W:0] cand;
      cand  = {s.rem, s.num[N-1]};
      n.num = s.num << 1;
      if (cand >= {1'b0, den}) begin
         n.rem  = STEP_W'(cand - {1'b0, den});
         n.quot = {s.quot[N-2:0], 1'b1};
      end else begin
         n.rem  = STEP_W'(cand);
         n.quot = {s.quot[N-2:0], 1'b0};
      end
      return n;
   endfunction

   logic [CP_W-1:0] col_prod;
   logic [N-1:0]    col_quot_in;
   logic [N-1:0]    col_ff  [0:N-1];
   dv_lane_type     pos_ff  [0:N-1];
   swd_ctrl_type    ctrl_ff [0:N-1];

   // The colour root always fits in the low bits, so one multiply gives the quotient.
   always_comb begin
      col_prod    = CP_W'(col_num[COL_ROOT_W-1:0]) * CP_W'(COL_RECIP);
      col_quot_in = N'(col_prod >> COL_RECIP_SHIFT);
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic [N-1:0] col_src;
      dv_lane_type  pos_src;
      swd_ctrl_type ctrl_src;

      if (g == 0) begin : g_head
         always_comb begin
            col_src      = col_quot_in;
            pos_src.num  = pos_num;
            pos_src.rem  = '0;
            pos_src.quot = '0;
            ctrl_src     = ctrl_i;
         end
      end else begin : g_body
         always_comb begin
            col_src  = col_ff[g-1];
            pos_src  = pos_ff[g-1];
            ctrl_src = ctrl_ff[g-1];
         end
      end

      // The grid step rides with the item, so each stage uses its own copy.
      always_ff @(posedge clock) begin
         col_ff[g] <= col_src;
         pos_ff[g] <= div_step(pos_src, ctrl_src.step);
         if (reset) begin
            ctrl_ff[g].valid <= 1'b0;
         end else begin
            ctrl_ff[g] <= ctrl_src;
         end
      end
   end

   assign col_quot = col_ff[N-1];
   assign pos_quot = pos_ff[N-1].quot;
   assign ctrl_o   = ctrl_ff[N-1];

endmodule

/* rtl/swd_checker.sv */
// Port-level checks for the weighted distance core, bound to the top level.
// Depends on swd_pkg and the assertion macro header.
`include "superpixel_weighted_distance_core_macros.svh"

module swd_checker
   import swd_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [OUT_W-1:0]         rsp_weighted_distance
);

   localparam int LATENCY = swd_rad_width(COORD_BITS) + 4;

   // The core is never busy, so it can take an item in every cycle.
   `SWD_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

   // Reset clears every valid bit, so no strobe shows in the cycle after a reset edge.
   `SWD_ASSERT_RESET(a_quiet_after_reset, clock, reset, ##1 !rsp_valid)

   // Every result traces back to an item taken exactly one latency earlier.
   `SWD_ASSERT_IMPLY(a_result_has_item, clock, reset, rsp_valid, $past(start && !busy, LATENCY))

   // The height term alone bounds the distance from below by zero; the sum never
   // reaches the saturation level at any supported coordinate width.
   `SWD_ASSERT_IMPLY(a_no_saturation, clock, reset, rsp_valid, rsp_weighted_distance != OUT_MAX)

endmodule

bind superpixel_weighted_distance_core swd_checker #(
   .COORD_BITS (COORD_BITS)
) u_swd_checker (.*);
